// ----- hdl/pte_pkg.sv -----
// Shared types, codes and constants for the probe trigger emulator.
// Used by the front end, queue, back end and top level; depends on nothing else.
package pte_pkg;

  // Fixed field widths, 1/4096 mm units
  typedef logic signed [23:0] pos_t;
  typedef logic signed [15:0] height_t;

  localparam int CELL_W = 8;  // mesh cell address, wide enough for 15x15
  typedef logic [CELL_W-1:0] cell_t;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_SET_X   = 2'd0,
    OP_SET_Y   = 2'd1,
    OP_SET_Z   = 2'd2,
    OP_MESH_WR = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_X_OFFSET = 2'd0,
    REG_Y_OFFSET = 2'd1,
    REG_Z_TRIG   = 2'd2,
    REG_SHEET    = 2'd3
  } cfg_reg_t;

  // Work classes handed from front to back
  typedef enum logic [1:0] {
    CMD_CAL   = 2'd0,
    CMD_MESH  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    pos_t        x_offset;
    pos_t        y_offset;
    logic [15:0] z_trig;
    logic        sheet;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t kind;
    pos_t      px;
    pos_t      py;
    pos_t      pz;
    cell_t     cell_addr;
    height_t   height;
  } cmd_t;

  localparam logic [15:0] Z_TRIG_RESET = 16'd4096;

  // Bed geometry and trigger constants
  localparam int X_SPAN        = 1044480;     // 255 mm
  localparam int Y_SPAN        = 860160;      // 210 mm
  localparam int CAL_LIMIT     = 1677721600;  // (10 mm)^2 and 4 mm * 25 mm scale
  localparam int Z_SCALE       = 102400;      // 25 mm
  localparam int Z_SHEET_LIMIT = 20480;       // 5 mm
  localparam int Z_HYST        = 2048;        // 0.5 mm

  localparam int CAL_PTS = 4;
  localparam int CAL_X [CAL_PTS] = '{143360, 995328, 995328, 143360};
  localparam int CAL_Y [CAL_PTS] = '{45056, 45056, 831488, 831488};

  // Arithmetic widths for the calibration path
  localparam int DSQ_W = 50;  // square of a 25-bit difference
  localparam int D2_W  = 51;  // sum of two squares
  localparam int ZT_W  = 41;  // 24-bit Z times Z_SCALE
  localparam int SUM_W = 52;  // Z term plus squared distance

  // Built-in 7x7 bed map, row major
  localparam int MAP_CELLS = 49;
  localparam height_t DEFAULT_MAP [MAP_CELLS] = '{
    16'sd188,  16'sd320,  16'sd434,  16'sd529,  16'sd606,  16'sd666,  16'sd707,
    16'sd40,   16'sd165,  16'sd258,  16'sd319,  16'sd348,  16'sd345,  16'sd310,
    -16'sd84,  16'sd34,   16'sd110,  16'sd143,  16'sd134,  16'sd81,   -16'sd13,
    -16'sd184, -16'sd73,  -16'sd12,  16'sd0,    -16'sd38,  -16'sd126, -16'sd263,
    -16'sd261, -16'sd157, -16'sd107, -16'sd110, -16'sd166, -16'sd276, -16'sd439,
    -16'sd313, -16'sd217, -16'sd175, -16'sd186, -16'sd251, -16'sd369, -16'sd541,
    -16'sd341, -16'sd253, -16'sd216, -16'sd229, -16'sd292, -16'sd406, -16'sd570
  };

  // Reset content of a mesh cell: built-in map, zero past its end
  function automatic height_t default_height(cell_t idx);
    return (idx < CELL_W'(MAP_CELLS)) ? DEFAULT_MAP[idx[5:0]] : '0;
  endfunction

  // Clamp a 25-bit sum into the 24-bit position range
  function automatic pos_t sat_pos(logic signed [24:0] v);
    return (v[24] == v[23]) ? v[23:0] : {v[24], {23{~v[24]}}};
  endfunction

endpackage

// ----- hdl/pte_front.sv -----
// Front end: accepts input beats, keeps the axis positions, and classifies
// each item into a command for the back end. Depends on pte_pkg.
module pte_front #(
  parameter int MESH_POINTS = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic signed [23:0]   axis_value,
  input  logic [5:0]           cell_index,
  input  logic signed [15:0]   cell_height,
  input  pte_pkg::cfg_t        cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output pte_pkg::cmd_t        q_cmd
);

  localparam int CW = pte_pkg::CELL_W;

  pte_pkg::op_t        op;
  logic                accept;
  logic signed [24:0]  sum_x, sum_y, sum_z;
  pte_pkg::pos_t       pos_x, pos_y, pos_z;
  pte_pkg::pos_t       pos_x_next, pos_y_next, pos_z_next;
  pte_pkg::cell_t      cell_addr;
  logic                cell_ok;
  logic                want;
  pte_pkg::cmd_kind_t  kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign op       = pte_pkg::op_t'(opcode);

  // Offset and trigger-height adjust
  assign sum_x = 25'(axis_value) + 25'(cfg.x_offset);
  assign sum_y = 25'(axis_value) + 25'(cfg.y_offset);
  assign sum_z = 25'(axis_value) - $signed({9'd0, cfg.z_trig});

  assign cell_addr = CW'(cell_index);
  assign cell_ok   = cell_addr < CW'(MESH_POINTS * MESH_POINTS);

  // New positions and command class
  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    pos_z_next = pos_z;
    want       = 1'b0;
    kind       = pte_pkg::CMD_CAL;
    case (op)
      pte_pkg::OP_SET_X: begin
        pos_x_next = pte_pkg::sat_pos(sum_x);
        want       = !cfg.sheet;
      end
      pte_pkg::OP_SET_Y: begin
        pos_y_next = pte_pkg::sat_pos(sum_y);
        want       = !cfg.sheet;
      end
      pte_pkg::OP_SET_Z: begin
        pos_z_next = pte_pkg::sat_pos(sum_z);
        want       = 1'b1;
        kind       = cfg.sheet ? pte_pkg::CMD_MESH : pte_pkg::CMD_CAL;
      end
      pte_pkg::OP_MESH_WR: begin
        want = cell_ok;
        kind = pte_pkg::CMD_WRITE;
      end
      default: ;
    endcase
  end

  // Position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  // Command toward the queue; items with nothing to do are dropped here
  assign q_push          = accept && want;
  assign q_cmd.kind      = kind;
  assign q_cmd.px        = pos_x_next;
  assign q_cmd.py        = pos_y_next;
  assign q_cmd.pz        = pos_z_next;
  assign q_cmd.cell_addr = cell_addr;
  assign q_cmd.height    = cell_height;

endmodule

// ----- hdl/pte_fifo.sv -----
// Two-entry command queue between front and back end.
// Depends on pte_pkg for the command type.
module pte_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pte_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pte_pkg::cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pte_pkg::cmd_t     entry [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entry[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

endmodule

// ----- hdl/pte_back.sv -----
// Back end: executes queued commands. Holds the height mesh, runs the
// calibration-point and mesh checks, and owns the output register.
// Depends on pte_pkg.
module pte_back #(
  parameter int MESH_POINTS = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  pte_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  pte_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          trigger_level
);

  localparam int NP         = pte_pkg::CAL_PTS;
  localparam int MESH_CELLS = MESH_POINTS * MESH_POINTS;
  localparam int IDX_W      = $clog2(MESH_POINTS);
  localparam int ADDR_W     = $clog2(MESH_CELLS);
  localparam int CW         = pte_pkg::CELL_W;
  localparam int DSQ_W      = pte_pkg::DSQ_W;
  localparam int D2_W       = pte_pkg::D2_W;
  localparam int ZT_W       = pte_pkg::ZT_W;
  localparam int SUM_W      = pte_pkg::SUM_W;

  logic en, take;

  // Head decode
  logic signed [24:0]       dx [NP];
  logic signed [24:0]       dy [NP];
  logic signed [DSQ_W-1:0]  dsq_x [NP];
  logic signed [DSQ_W-1:0]  dsq_y [NP];
  logic signed [ZT_W-1:0]   zt;
  logic signed [24:0]       nx, ny;
  logic signed [31:0]       nxm, nym;
  logic [IDX_W-1:0]         col, row;
  logic [ADDR_W-1:0]        raddr, waddr;
  logic                     wr_en, zok;

  // Stage 1
  logic                     s1_cal, s1_mesh;
  logic signed [DSQ_W-1:0]  s1_dsq_x [NP];
  logic signed [DSQ_W-1:0]  s1_dsq_y [NP];
  logic signed [ZT_W-1:0]   s1_zt;
  pte_pkg::pos_t            s1_pz;
  logic                     s1_zok;
  pte_pkg::height_t         rd_data, rd_dflt;
  logic                     rd_vld;

  // Mesh store with per-cell written flags
  pte_pkg::height_t         mesh [MESH_CELLS];
  logic [MESH_CELLS-1:0]    written;

  // Stage 1 to 2
  pte_pkg::height_t         h;
  logic signed [16:0]       h_hys;
  logic                     le_h, le_hys;
  logic signed [D2_W-1:0]   d2 [NP];

  // Stage 2
  logic                     s2_cal, s2_has, s2_lvl;
  logic signed [D2_W-1:0]   s2_d2 [NP];
  logic signed [ZT_W-1:0]   s2_zt;

  // Stage 2 to output
  logic                     res_has, res_lvl;
  logic                     near [NP];
  logic                     hit  [NP];

  // Whole pipe advances unless a result waits at the output
  assign en    = !out_valid || out_ready;
  assign take  = en && q_valid;
  assign q_pop = take;

  // Squared distances to each calibration point
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      dx[i]    = 25'(q_head.px) - 25'(pte_pkg::CAL_X[i]);
      dy[i]    = 25'(q_head.py) - 25'(pte_pkg::CAL_Y[i]);
      dsq_x[i] = DSQ_W'(dx[i]) * DSQ_W'(dx[i]);
      dsq_y[i] = DSQ_W'(dy[i]) * DSQ_W'(dy[i]);
    end
  end

  assign zt = ZT_W'(q_head.pz) * ZT_W'(pte_pkg::Z_SCALE);

  // Mesh cell lookup: column rounds, row floors, both clamp
  assign nx  = 25'(q_head.px) - 25'(cfg.x_offset);
  assign ny  = 25'(q_head.py) - 25'(cfg.y_offset);
  assign nxm = 32'(nx) * 32'(2 * MESH_POINTS);
  assign nym = 32'(ny) * 32'(MESH_POINTS);

  always_comb begin
    col = '0;
    row = '0;
    for (int k = 1; k < MESH_POINTS; k++) begin
      if (nxm >= 32'(pte_pkg::X_SPAN * (2 * k - 1))) col = IDX_W'(k);
      if (nym >= 32'(pte_pkg::Y_SPAN * k))           row = IDX_W'(k);
    end
  end

  assign raddr = ADDR_W'(col) + ADDR_W'(row) * ADDR_W'(MESH_POINTS);
  assign waddr = q_head.cell_addr[ADDR_W-1:0];
  assign wr_en = take && (q_head.kind == pte_pkg::CMD_WRITE);
  assign zok   = q_head.pz <= 24'(pte_pkg::Z_SHEET_LIMIT);

  // Mesh memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mesh[waddr] <= q_head.height;
    if (en) begin
      rd_data <= mesh[raddr];
      rd_dflt <= pte_pkg::default_height(CW'(raddr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[waddr] <= 1'b1;
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_cal  <= 1'b0;
      s1_mesh <= 1'b0;
    end else if (en) begin
      s1_cal  <= q_valid && (q_head.kind == pte_pkg::CMD_CAL);
      s1_mesh <= q_valid && (q_head.kind == pte_pkg::CMD_MESH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NP; i++) begin
        s1_dsq_x[i] <= dsq_x[i];
        s1_dsq_y[i] <= dsq_y[i];
      end
      s1_zt  <= zt;
      s1_pz  <= q_head.pz;
      s1_zok <= zok;
      rd_vld <= written[raddr];
    end
  end

  // Mesh compare with hysteresis band, and distance sums
  assign h      = rd_vld ? rd_data : rd_dflt;
  assign h_hys  = 17'(h) + 17'(pte_pkg::Z_HYST);
  assign le_h   = s1_pz <= 24'(h);
  assign le_hys = s1_pz <= 24'(h_hys);

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      d2[i] = D2_W'(s1_dsq_x[i]) + D2_W'(s1_dsq_y[i]);
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_cal <= 1'b0;
      s2_has <= 1'b0;
    end else if (en) begin
      s2_cal <= s1_cal;
      s2_has <= s1_mesh && s1_zok && (le_h || le_hys);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NP; i++) begin
        s2_d2[i] <= d2[i];
      end
      s2_zt  <= s1_zt;
      s2_lvl <= le_h;
    end
  end

  // Calibration commands: the first calibration point in range decides the level; mesh results pass through
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      near[i] = s2_d2[i] < D2_W'(pte_pkg::CAL_LIMIT);
      hit[i]  = (SUM_W'(s2_zt) + SUM_W'(s2_d2[i])) <= SUM_W'(pte_pkg::CAL_LIMIT);
    end
    res_has = s2_has;
    res_lvl = s2_lvl;
    if (s2_cal) begin
      res_has = 1'b0;
      res_lvl = 1'b0;
      for (int i = NP - 1; i >= 0; i--) begin
        if (near[i]) begin
          res_has = 1'b1;
          res_lvl = hit[i];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= res_has;
    end
  end

  always_ff @(posedge clk) begin
    if (en) trigger_level <= res_lvl;
  end

endmodule

// ----- hdl/probe_trigger_emulator.sv -----
// Bed-leveling proximity probe emulator.
//
// Input channel (in_valid/in_ready): one beat per opcode: set X, Y or Z,
// or write one cell of the height mesh. Output channel (out_valid/
// out_ready): trigger_level beats; an input beat makes zero or one.
// Configuration: cfg_write with cfg_index/cfg_data writes one register
// in the same cycle; write only while the block is idle.
//
// Throughput is one input beat per cycle while out_ready is high. A result
// is presented once its beat has passed through the command queue, then
// two back-end stages (squares and mesh read, then distance sums and mesh
// compare) and into the output register.
//
// Reset clears positions, sets the registers to their defaults and marks
// every mesh cell unwritten, so the mesh reads as the built-in bed map at
// once; no clearing pass is needed.
// When a result waits with out_ready low the back end holds; the two-entry
// queue keeps taking beats until it fills, then in_ready drops.
module probe_trigger_emulator #(
  parameter int MESH_POINTS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [23:0] axis_value,
  input  logic [5:0]         cell_index,
  input  logic signed [15:0] cell_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               trigger_level,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  pte_pkg::pos_t  x_offset, y_offset;
  logic [15:0]    z_trig;
  logic           sheet;
  pte_pkg::cfg_t  cfg;

  logic           q_push, q_full, q_pop, q_valid;
  pte_pkg::cmd_t  q_cmd, q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= '0;
      y_offset <= '0;
      z_trig   <= pte_pkg::Z_TRIG_RESET;
      sheet    <= 1'b1;
    end else if (cfg_write) begin
      case (pte_pkg::cfg_reg_t'(cfg_index))
        pte_pkg::REG_X_OFFSET: x_offset <= cfg_data;
        pte_pkg::REG_Y_OFFSET: y_offset <= cfg_data;
        pte_pkg::REG_Z_TRIG:   z_trig   <= cfg_data[15:0];
        pte_pkg::REG_SHEET:    sheet    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.x_offset = x_offset;
  assign cfg.y_offset = y_offset;
  assign cfg.z_trig   = z_trig;
  assign cfg.sheet    = sheet;

  pte_front #(.MESH_POINTS(MESH_POINTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .axis_value  (axis_value),
    .cell_index  (cell_index),
    .cell_height (cell_height),
    .cfg         (cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  pte_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  pte_back #(.MESH_POINTS(MESH_POINTS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_level (trigger_level)
  );

endmodule

// ----- hdl/pte_checker.sv -----
// Port-level checks for the probe trigger emulator, bound to the top level.
// Depends only on the top-level ports.
module pte_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic trigger_level
);

  // Reset leaves no result beat pending
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Reset leaves the queue empty, so input is open
  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  // With no result waiting the back end drains, so the queue cannot be full
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // A stalled result beat holds its level
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(trigger_level))
    else $error("result beat changed while stalled");

endmodule

bind probe_trigger_emulator pte_checker u_pte_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .trigger_level (trigger_level)
);
